// ----- sv/nwm_pkg.sv -----
package nwm_pkg;

  // Week selector and weekday codes
  localparam logic [2:0] ChoiceFifth  = 3'd4;
  localparam logic [2:0] ChoiceLast   = 3'd5;
  localparam logic [2:0] ChoiceTeenth = 3'd6;
  localparam logic [2:0] WeekdayBad   = 3'd7;

  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthDec = 4'd12;

  // floor(x / 100) == (x * Recip100) >> Recip100Shift for x below 2**15
  localparam int unsigned Recip100      = 5243;
  localparam int unsigned Recip100Shift = 19;
  localparam int unsigned ProdW         = 15 + 13;

  localparam logic [14:0] YearBias = 15'd400;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [2:0]  choice;
    logic [2:0]  wd;
  } query_t;

  // after century split
  typedef struct packed {
    logic        ok;
    logic [14:0] yy;
    logic [7:0]  cent;      // yy / 100
    logic [13:0] year;
    logic [7:0]  year_cent; // year / 100
    logic [3:0]  month;
    logic [3:0]  mm;        // Zeller month, 3..14
    logic [2:0]  choice;
    logic [2:0]  wd;
  } split_t;

  // after Zeller sum
  typedef struct packed {
    logic        ok;
    logic [10:0] zsum;
    logic [4:0]  dim;
    logic [2:0]  choice;
    logic [2:0]  wd;
  } zsum_t;

  // after weekday resolve
  typedef struct packed {
    logic       ok;
    logic [2:0] ofs;        // first hit - 1, 0..6
    logic [4:0] dim;
    logic [2:0] choice;
  } wkday_t;

  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] d;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                      d = 5'd30;
      4'd2:                                         d = 5'd28;
      default:                                      d = 5'd0;
    endcase
    return d;
  endfunction

  // floor(13 * (mm + 1) / 5)
  function automatic logic [5:0] zeller_month_term(input logic [3:0] mm);
    logic [5:0] t;
    unique case (mm)
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      4'd13:   t = 6'd36;
      4'd14:   t = 6'd39;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

// ----- sv/nwm_split.sv -----
module nwm_split (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  nwm_pkg::query_t data_i,
  output logic            valid_o,
  output nwm_pkg::split_t data_o
);
  import nwm_pkg::*;

  logic            valid_q;
  split_t          data_q, data_d;
  logic [14:0]     yy;
  logic [ProdW-1:0] prod_yy, prod_y;

  always_comb begin
    data_d.ok = (data_i.month >= MonthJan) && (data_i.month <= MonthDec) &&
                (data_i.wd != WeekdayBad) && (data_i.choice <= ChoiceTeenth);
    if (data_i.month <= MonthFeb) begin
      yy         = {1'b0, data_i.year} + YearBias - 15'd1;
      data_d.mm  = data_i.month + 4'd12;
    end else begin
      yy         = {1'b0, data_i.year} + YearBias;
      data_d.mm  = data_i.month;
    end
    prod_yy = ProdW'(yy) * ProdW'(Recip100);
    prod_y  = ProdW'(data_i.year) * ProdW'(Recip100);
    data_d.yy        = yy;
    data_d.cent      = prod_yy[Recip100Shift +: 8];
    data_d.year      = data_i.year;
    data_d.year_cent = prod_y[Recip100Shift +: 8];
    data_d.month     = data_i.month;
    data_d.choice    = data_i.choice;
    data_d.wd        = data_i.wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- sv/nwm_zsum.sv -----
module nwm_zsum (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  nwm_pkg::split_t data_i,
  output logic            valid_o,
  output nwm_pkg::zsum_t  data_o
);
  import nwm_pkg::*;

  logic        valid_q;
  zsum_t       data_q, data_d;
  logic [6:0]  k;
  logic [6:0]  rem100;
  logic        leap;

  always_comb begin
    // remainders by 100 from the registered quotients
    k      = 7'(data_i.yy - 15'(data_i.cent) * 15'd100);
    rem100 = 7'(data_i.year - 14'(data_i.year_cent) * 14'd100);
    leap   = ((data_i.year[1:0] == 2'b00) && (rem100 != 7'd0)) ||
             ((rem100 == 7'd0) && (data_i.year_cent[1:0] == 2'b00));

    data_d.zsum = 11'd1 + 11'(zeller_month_term(data_i.mm)) + 11'(k) + 11'(k[6:2]) +
                  11'(data_i.cent[7:2]) + 11'(data_i.cent) * 11'd5;
    data_d.dim  = month_days(data_i.month);
    if ((data_i.month == MonthFeb) && leap) begin
      data_d.dim = 5'd29;
    end
    data_d.ok     = data_i.ok;
    data_d.choice = data_i.choice;
    data_d.wd     = data_i.wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- sv/nwm_wkday.sv -----
module nwm_wkday (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  nwm_pkg::zsum_t  data_i,
  output logic            valid_o,
  output nwm_pkg::wkday_t data_o
);
  import nwm_pkg::*;

  logic        valid_q;
  wkday_t      data_q, data_d;
  logic [4:0]  fold1;
  logic [3:0]  fold2;
  logic [2:0]  h;
  logic [2:0]  first_wd;

  always_comb begin
    // mod 7 by folding octal digits (8 == 1 mod 7)
    fold1 = 5'(data_i.zsum[2:0]) + 5'(data_i.zsum[5:3]) + 5'(data_i.zsum[8:6]) +
            5'(data_i.zsum[10:9]);
    fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
    h     = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
    // Zeller counts from Saturday; shift to Sunday = 0
    first_wd = (h == 3'd0) ? 3'd6 : h - 3'd1;

    data_d.ofs    = (data_i.wd >= first_wd) ? data_i.wd - first_wd
                                            : data_i.wd + 3'd7 - first_wd;
    data_d.ok     = data_i.ok;
    data_d.dim    = data_i.dim;
    data_d.choice = data_i.choice;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- sv/nwm_select.sv -----
module nwm_select (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  nwm_pkg::wkday_t data_i,
  output logic            valid_o,
  output logic [4:0]      day_o
);
  import nwm_pkg::*;

  logic       valid_q;
  logic [4:0] day_q, day_d;
  logic [2:0] first_hit;
  logic [5:0] nth_day;
  logic [5:0] fifth_day;
  logic [4:0] teenth_day;

  always_comb begin
    first_hit  = data_i.ofs + 3'd1;
    nth_day    = 6'(first_hit) + 6'(data_i.choice) * 6'd7;
    fifth_day  = 6'(first_hit) + 6'd28;
    teenth_day = (data_i.ofs >= 3'd5) ? 5'd13 + 5'(data_i.ofs - 3'd5)
                                      : 5'd15 + 5'(data_i.ofs);
    day_d = 5'd0;
    if (data_i.ok) begin
      priority if (data_i.choice <= ChoiceFifth) begin
        day_d = (nth_day <= 6'(data_i.dim)) ? nth_day[4:0] : 5'd0;
      end else if (data_i.choice == ChoiceLast) begin
        // last hit is the fifth when it fits, else the fourth
        day_d = (fifth_day <= 6'(data_i.dim)) ? fifth_day[4:0]
                                              : 5'(first_hit) + 5'd21;
      end else begin
        day_d = teenth_day;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      day_q <= day_d;
    end
  end

  assign valid_o = valid_q;
  assign day_o   = day_q;

endmodule

// ----- sv/nth_weekday_of_month_core.sv -----
// Meetup-day calculator: given a Gregorian year, month, week selector and
// weekday (Sunday = 0), returns the day of the month on which that
// occurrence falls, or 0 for an invalid query or a missing fifth hit.
//
// Input channel: in_valid_i / in_stall_o with year_i, month_i,
// week_choice_i, weekday_i. A transfer happens on a rising edge with
// valid high and stall low. Output channel: out_valid_o / out_stall_i
// with day_of_month_o, same rule.
//
// Four register stages: century split (reciprocal multiply), Zeller sum
// and month length, mod-7 weekday resolve, selection into the output
// register. A query passes the stages in that order and holds on the
// output until it is taken. Throughput is one query per cycle while
// the receiver does not stall.
//
// Reset clears the stage valid bits only; the pipe comes up empty and
// ready. When the receiver stalls, the output holds and stages fill up
// behind it; in_stall_o rises only once every stage holds a query, so no
// query is dropped or repeated.
module nth_weekday_of_month_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [13:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [2:0]  week_choice_i,
  input  logic [2:0]  weekday_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  day_of_month_o
);
  import nwm_pkg::*;

  query_t query;
  split_t split_data;
  zsum_t  zsum_data;
  wkday_t wkday_data;

  logic split_vld, zsum_vld, wkday_vld;
  // a stage advances when it is empty or the next one advances
  logic en_split, en_zsum, en_wkday, en_sel;

  assign query.year   = year_i;
  assign query.month  = month_i;
  assign query.choice = week_choice_i;
  assign query.wd     = weekday_i;

  assign en_sel   = !out_valid_o || !out_stall_i;
  assign en_wkday = !wkday_vld || en_sel;
  assign en_zsum  = !zsum_vld || en_wkday;
  assign en_split = !split_vld || en_zsum;

  assign in_stall_o = !en_split;

  nwm_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_split),
    .valid_i (in_valid_i),
    .data_i  (query),
    .valid_o (split_vld),
    .data_o  (split_data)
  );

  nwm_zsum u_zsum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_zsum),
    .valid_i (split_vld),
    .data_i  (split_data),
    .valid_o (zsum_vld),
    .data_o  (zsum_data)
  );

  nwm_wkday u_wkday (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_wkday),
    .valid_i (zsum_vld),
    .data_i  (zsum_data),
    .valid_o (wkday_vld),
    .data_o  (wkday_data)
  );

  nwm_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_sel),
    .valid_i (wkday_vld),
    .data_i  (wkday_data),
    .valid_o (out_valid_o),
    .day_o   (day_of_month_o)
  );

  // back-pressure to the sender only when every stage is occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (split_vld && zsum_vld && wkday_vld && out_valid_o && out_stall_i))
    else $error("input stalled with a bubble in the pipe");

  // for a valid query the offset from the first weekday is a weekday distance
  a_ofs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wkday_vld && wkday_data.ok) |-> (wkday_data.ofs <= 3'd6))
    else $error("weekday offset out of range");

  // an invalid query leaving stage three puts day 0 into the output register
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wkday_vld && en_sel && !wkday_data.ok) |=> (day_of_month_o == 5'd0))
    else $error("invalid query produced a nonzero day");

endmodule
